// ===== hdl/lr_pkg.sv =====
// line rasterizer shared definitions: default coordinate width, queue depth
// and the status flags the command queue reports to the rest of the block
// no dependencies
`timescale 1ns / 1ps

package lr_pkg;

	// default coordinate width and depth of the command queue
	localparam int COORD_BITS_DEF = 6;
	localparam int QUEUE_DEPTH    = 2;

	// fill status of the command queue
	typedef struct packed {
		logic full;
		logic empty;
	} lr_qstat_t;

endpackage

// ===== hdl/lr_front.sv =====
// line rasterizer front end: takes a line command and works out direction,
// major axis, pixel count and the initial decision terms of the line
// depends on lr_pkg
`timescale 1ns / 1ps

module lr_front
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      start,
	input  logic                      full,
	input  logic [COORD_BITS-1:0]     start_x,
	input  logic [COORD_BITS-1:0]     start_y,
	input  logic [COORD_BITS-1:0]     end_x,
	input  logic [COORD_BITS-1:0]     end_y,
	output logic                      push,
	output logic [6*COORD_BITS+8:0]   job
);

	localparam int DW = COORD_BITS + 2;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  sx_neg;
		logic                  sy_neg;
		logic                  x_major;
		logic [COORD_BITS-1:0] count;
		logic signed [DW-1:0]  d;
		logic signed [DW-1:0]  inc_step;
		logic signed [DW-1:0]  inc_stay;
	} job_t;

	logic                  x_fwd;
	logic                  y_fwd;
	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic                  x_major;
	logic [COORD_BITS-1:0] major;
	logic [COORD_BITS-1:0] minor;
	logic signed [DW-1:0]  major_s;
	logic signed [DW-1:0]  minor_s;
	job_t                  j;

	// a transaction is taken when start is high and the queue has room
	assign push = start && !full;

	// extents and stepping direction on each axis
	assign x_fwd = (end_x >= start_x);
	assign y_fwd = (end_y >= start_y);
	assign adx   = x_fwd ? (end_x - start_x) : (start_x - end_x);
	assign ady   = y_fwd ? (end_y - start_y) : (start_y - end_y);

	// x is major on equal extents
	assign x_major = (adx >= ady);
	assign major   = x_major ? adx : ady;
	assign minor   = x_major ? ady : adx;
	assign major_s = $signed({2'b00, major});
	assign minor_s = $signed({2'b00, minor});

	// command record for the stepper
	always_comb begin
		j.x        = start_x;
		j.y        = start_y;
		j.sx_neg   = !x_fwd;
		j.sy_neg   = !y_fwd;
		j.x_major  = x_major;
		j.count    = major;
		j.d        = (minor_s <<< 1) - major_s;
		j.inc_step = (minor_s - major_s) <<< 1;
		j.inc_stay = minor_s <<< 1;
	end

	assign job = j;

endmodule

// ===== hdl/lr_queue.sv =====
// line rasterizer command queue: small fifo of prepared line commands that
// decouples the front end from the pixel stepper
// depends on lr_pkg
`timescale 1ns / 1ps

module lr_queue
	import lr_pkg::*;
#(
	parameter int W     = 45,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output lr_qstat_t    qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	// status
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rdata       = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/lr_stepper.sv =====
// line rasterizer back end: loads one prepared command from the queue and
// steps the bresenham decision once per pixel, one pixel per cycle
// depends on lr_pkg
`timescale 1ns / 1ps

module lr_stepper
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lr_qstat_t               qstat,
	input  logic [6*COORD_BITS+8:0] job,
	output logic                    pop,
	output logic                    strobe,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output logic                    last_pixel
);

	localparam int DW = COORD_BITS + 2;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  sx_neg;
		logic                  sy_neg;
		logic                  x_major;
		logic [COORD_BITS-1:0] count;
		logic signed [DW-1:0]  d;
		logic signed [DW-1:0]  inc_step;
		logic signed [DW-1:0]  inc_stay;
	} job_t;

	job_t                  j;
	logic                  active_q;
	logic                  strobe_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [COORD_BITS-1:0] cnt_q;
	logic                  sx_neg_q;
	logic                  sy_neg_q;
	logic                  x_major_q;
	logic signed [DW-1:0]  d_q;
	logic signed [DW-1:0]  inc_step_q;
	logic signed [DW-1:0]  inc_stay_q;
	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic                  last_q;
	logic                  minor_step;
	logic                  x_adv;
	logic                  y_adv;
	logic                  at_end;

	assign j = job;

	// take the next command once the current line is done
	assign pop = !active_q && !qstat.empty;

	// decision and axis advance for the current pixel
	assign minor_step = !d_q[DW-1] && (d_q != '0);
	assign x_adv      = x_major_q || minor_step;
	assign y_adv      = !x_major_q || minor_step;
	assign at_end     = (cnt_q == '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
			end else if (active_q && at_end) begin
				active_q <= 1'b0;
			end
		end
	end

	// line state and output pixel
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q        <= j.x;
			y_q        <= j.y;
			cnt_q      <= j.count;
			sx_neg_q   <= j.sx_neg;
			sy_neg_q   <= j.sy_neg;
			x_major_q  <= j.x_major;
			d_q        <= j.d;
			inc_step_q <= j.inc_step;
			inc_stay_q <= j.inc_stay;
		end else if (active_q) begin
			if (x_adv) begin
				x_q <= sx_neg_q ? (x_q - 1'b1) : (x_q + 1'b1);
			end
			if (y_adv) begin
				y_q <= sy_neg_q ? (y_q - 1'b1) : (y_q + 1'b1);
			end
			d_q   <= minor_step ? (d_q + inc_step_q) : (d_q + inc_stay_q);
			cnt_q <= cnt_q - 1'b1;
		end
		px_q   <= x_q;
		py_q   <= y_q;
		last_q <= at_end;
	end

	assign strobe     = strobe_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign last_pixel = last_q;

endmodule

// ===== hdl/line_rasterizer_core.sv =====
// line rasterizer top level: bresenham line generator for all octants
// depends on lr_pkg, lr_front, lr_queue, lr_stepper
//
// usage
//   command channel: drive start_x/start_y/end_x/end_y with start high; the
//   transaction is taken at a rising edge where start is high and busy is
//   low. busy is high while the command queue holds two waiting lines.
//   pixel channel: one pixel per cycle within a line on pixel_x/pixel_y, marked by
//   strobe for exactly one cycle; last_pixel is high on the end point.
//   the receiver cannot stall, so pixels are never held back.
// line timing
//   a taken command waits in the queue while the stepper is busy; its first
//   pixel then passes through the stepper's line state and its output
//   register. a line of major extent m gives m+1 pixels in consecutive
//   cycles. the stepper draws one line at a time and loads the next command
//   only once the current line is done; the queue takes commands meanwhile.
// reset
//   arst_n low empties the queue and stops the stepper; no pixel is
//   emitted until a new command is taken.
`timescale 1ns / 1ps

module line_rasterizer_core
	import lr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  strobe,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last_pixel
);

	localparam int JOB_W = 6 * COORD_BITS + 9;

	logic             push;
	logic             pop;
	logic [JOB_W-1:0] job_in;
	logic [JOB_W-1:0] job_out;
	lr_qstat_t        qstat;

	assign busy = qstat.full;

	// command classification
	lr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.start   (start),
		.full    (qstat.full),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.push    (push),
		.job     (job_in)
	);

	// command queue
	lr_queue #(
		.W     (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.qstat  (qstat)
	);

	// pixel stepper
	lr_stepper #(
		.COORD_BITS(COORD_BITS)
	) u_stepper (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.job        (job_out),
		.pop        (pop),
		.strobe     (strobe),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

	// queue never underflows
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty command queue");

	// queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full command queue");

	// an accepted command is held in the queue the next cycle
	a_cmd_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !qstat.empty)
		else $error("accepted command missing from queue");

	// pixels of one line come in consecutive cycles
	a_line_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_pixel) |=> strobe)
		else $error("gap inside a line");

endmodule
